FILE: hw/rtl/gcub_pkg.sv
// Shared types and constants for the glyph coverage unpack and blend block.
// Used by the front end, the item queue, the back end and the top level.
// No dependencies.
`default_nettype none

package gcub_pkg;

   // Bits-per-pixel codes held in the depth register.
   localparam logic [1:0] DEPTH_1BPP = 2'd0;
   localparam logic [1:0] DEPTH_2BPP = 2'd1;
   localparam logic [1:0] DEPTH_4BPP = 2'd2;
   localparam logic [1:0] DEPTH_8BPP = 2'd3;
   localparam logic [1:0] DEPTH_RESET = DEPTH_8BPP;

   // Register index of depth_code, taken from address bit 2.
   localparam logic REG_DEPTH_CODE = 1'b0;
   localparam int   CSR_ADDR_W = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // 65535 / 15; (x + 1) * RECIP_15 >> 16 equals x / 15 for x below 65535.
   localparam logic [12:0] RECIP_15 = 13'd4369;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [3:0]  count;
      logic [15:0] back_color;
      logic [15:0] fore_color;
      logic        glyph_end;
      logic [1:0]  depth;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/glyph_coverage_unpack_blend_core.sv
// Glyph coverage unpack and blend: each request carries one packed glyph byte and two
// 4x4-bit colors; the block emits one blended 32-bit pixel per clock unless rsp_stall
// holds it, and clamps each request's pixel count to the byte capacity (up to eight
// pixels at one bit per pixel). The back end's unpack sequencer issues one pixel per
// cycle while the blend stage is free into a two-stage blend pipeline (products, then
// the divide by 15). A four-entry queue lets the request side run ahead.
// Requests with a zero count produce nothing. The user must write the depth register
// (address 0) only while the block is idle; the block itself does not enforce it.
`default_nettype none

module glyph_coverage_unpack_blend_core import gcub_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic [3:0]            req_pixel_count,
   input  wire logic [15:0]           req_back_color,
   input  wire logic [15:0]           req_fore_color,
   input  wire logic                  req_glyph_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [31:0]                rsp_pixel_word,
   output logic                       rsp_last_pixel,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic [1:0]       depth_ff;
   logic             q_push, q_pop;
   item_type         push_item, head_item;
   queue_status_type q_status;
   logic             wr_depth;

   assign pready   = 1'b1;
   assign wr_depth = psel && penable && pwrite && (paddr[2] == REG_DEPTH_CODE);
   assign prdata   = (paddr[2] == REG_DEPTH_CODE) ? {30'd0, depth_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else if (wr_depth) begin
         depth_ff <= pwdata[1:0];
      end
   end

   gcub_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_pixel_count (req_pixel_count),
      .req_back_color  (req_back_color),
      .req_fore_color  (req_fore_color),
      .req_glyph_end   (req_glyph_end),
      .depth           (depth_ff),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   gcub_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   gcub_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_item      (head_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_word (rsp_pixel_word),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/gcub_front.sv
// Front end: accepts requests, clamps the pixel count to the byte capacity
// and drops requests that emit nothing. Depends on gcub_pkg.
`default_nettype none

module gcub_front import gcub_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic [3:0]       req_pixel_count,
   input  wire logic [15:0]      req_back_color,
   input  wire logic [15:0]      req_fore_color,
   input  wire logic             req_glyph_end,
   input  wire logic [1:0]       depth,
   input  wire queue_status_type q_status,
   output logic                  q_push,
   output item_type              q_item
);

   logic     f_valid_ff, f_valid_in;
   item_type f_item_ff;
   logic     accept;
   logic [3:0] per_byte;
   logic [3:0] clamped;

   assign per_byte = 4'd8 >> depth;
   assign clamped  = (req_pixel_count > per_byte) ? per_byte : req_pixel_count;

   assign req_stall = f_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = f_valid_ff && !q_status.full;
   assign q_item    = f_item_ff;

   always_comb begin
      if (accept && (clamped != 4'd0)) begin
         f_valid_in = 1'b1;
      end else if (q_push) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_item_ff.data_byte  <= req_data_byte;
         f_item_ff.count      <= clamped;
         f_item_ff.back_color <= req_back_color;
         f_item_ff.fore_color <= req_fore_color;
         f_item_ff.glyph_end  <= req_glyph_end;
         f_item_ff.depth      <= depth;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/gcub_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on gcub_pkg.
`default_nettype none

module gcub_queue import gcub_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire item_type    push_item,
   input  wire logic        pop,
   output item_type         head_item,
   output queue_status_type status
);

   item_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff, fill_in;

   assign status.full      = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.not_empty = (fill_ff != '0);
   assign head_item        = entries_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/gcub_back.sv
// Back end: unpacks one pixel per unstalled cycle from the current item, forms the
// blend sums, divides by 15 and drives the response register. Depends on gcub_pkg.
`default_nettype none

module gcub_back import gcub_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire item_type         head_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [31:0]           rsp_pixel_word,
   output logic                  rsp_last_pixel
);

   // Current item and unpack position.
   logic       cur_valid_ff, cur_valid_in;
   item_type   cur_ff;
   logic [7:0] shreg_ff;
   logic [2:0] idx_ff;

   // Blend sum stage.
   logic        s1_valid_ff, s1_valid_in;
   logic [11:0] s1_sum_ff [4];
   logic        s1_last_ff;

   // Response register.
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff;
   logic        out_last_ff;

   logic out_free, s1_free, s1_adv, issue, is_last, done;
   logic [7:0] coverage, uncover, shifted;
   logic [11:0] sum [4];
   logic [31:0] word;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_adv   = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || out_free;
   assign issue    = cur_valid_ff && s1_free;
   assign is_last  = (({1'b0, idx_ff} + 4'd1) == cur_ff.count);
   assign done     = issue && is_last;
   assign q_pop    = q_status.not_empty && (!cur_valid_ff || done);

   // Coverage from the top pixel; replicating the value scales it to 0..255.
   always_comb begin
      unique case (cur_ff.depth)
         DEPTH_1BPP: begin
            coverage = {8{shreg_ff[7]}};
            shifted  = {shreg_ff[6:0], 1'b0};
         end
         DEPTH_2BPP: begin
            coverage = {4{shreg_ff[7:6]}};
            shifted  = {shreg_ff[5:0], 2'b0};
         end
         DEPTH_4BPP: begin
            coverage = {2{shreg_ff[7:4]}};
            shifted  = {shreg_ff[3:0], 4'b0};
         end
         default: begin
            coverage = shreg_ff;
            shifted  = 8'd0;
         end
      endcase
   end

   assign uncover = 8'hff - coverage;

   always_comb begin
      for (int t = 0; t < 4; t++) begin
         sum[t] = 12'(uncover) * 12'(cur_ff.back_color[4*t +: 4])
                + 12'(coverage) * 12'(cur_ff.fore_color[4*t +: 4]);
      end
   end

   always_comb begin
      logic [24:0] prod;
      prod = '0;
      for (int t = 0; t < 4; t++) begin
         prod = 25'(s1_sum_ff[t] + 12'd1) * 25'(RECIP_15);
         word[8*t +: 8] = prod[23:16];
      end
   end

   always_comb begin
      if (q_pop) begin
         cur_valid_in = 1'b1;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else begin
         cur_valid_in = cur_valid_ff;
      end
   end

   always_comb begin
      s1_valid_in  = s1_free ? issue : s1_valid_ff;
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff   <= head_item;
         shreg_ff <= head_item.data_byte;
         idx_ff   <= 3'd0;
      end else if (issue) begin
         shreg_ff <= shifted;
         idx_ff   <= idx_ff + 3'd1;
      end
      if (issue) begin
         for (int t = 0; t < 4; t++) begin
            s1_sum_ff[t] <= sum[t];
         end
         s1_last_ff <= is_last && cur_ff.glyph_end;
      end
      if (s1_adv) begin
         out_word_ff <= word;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_word = out_word_ff;
   assign rsp_last_pixel = out_last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> ({1'b0, idx_ff} < cur_ff.count))
      else $error("unpack position ran past the pixel count");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("blend stage dropped a pixel while the output stalled");

   a_no_issue_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && rsp_stall) |-> !issue)
      else $error("pixel issued into an occupied blend stage");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!cur_valid_ff || done))
      else $error("queue popped while the current item still had pixels");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for glyph_coverage_unpack_blend_core: directed and random
// glyph bytes at every pixel depth, predicted pixel by pixel and checked in order.
// Depends on gcub_pkg and the core RTL only.

module tb_top import gcub_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] ADDR_DEPTH = {REG_DEPTH_CODE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = {~REG_DEPTH_CODE, 2'b00};
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES = 120;
   localparam int ITEMS_PER_DEPTH = 32;
   localparam int MAX_REPORTS = 10;
   localparam real TIMEOUT_NS = 400_000.0;

   typedef struct {
      logic [31:0] pixel_word;
      logic        last_pixel;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = '0;
   logic [3:0]            req_pixel_count = '0;
   logic [15:0]           req_back_color = '0;
   logic [15:0]           req_fore_color = '0;
   logic                  req_glyph_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [31:0]           rsp_pixel_word;
   logic                  rsp_last_pixel;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   pixel_result_type expected_pixels[$];
   logic [1:0]       model_depth = DEPTH_RESET;
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_pending = 0;
   int               hold_taken = 0;
   int               hold_left = 0;

   glyph_coverage_unpack_blend_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_pixel_count (req_pixel_count),
      .req_back_color  (req_back_color),
      .req_fore_color  (req_fore_color),
      .req_glyph_end   (req_glyph_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_word  (rsp_pixel_word),
      .rsp_last_pixel  (rsp_last_pixel),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #1 clock = ~clock;

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
      end
   endfunction

   // Each 4-bit channel is mixed by coverage and divided by 15, truncated.
   function automatic logic [31:0] blend_pixel(logic [7:0] coverage, logic [15:0] back,
                                               logic [15:0] fore);
      logic [31:0] word;
      int unsigned inv;
      int unsigned chan;
      word = '0;
      inv = 255 - coverage;
      for (int t = 0; t < 4; t++) begin
         chan = (inv * back[4*t +: 4] + coverage * fore[4*t +: 4]) / 15;
         word[8*t +: 8] = chan[7:0];
      end
      return word;
   endfunction

   function automatic void predict_pixels(logic [7:0] data, logic [3:0] count,
                                          logic [15:0] back, logic [15:0] fore,
                                          logic glyph_end);
      int unsigned      bpp;
      int unsigned      per_byte;
      int unsigned      emitted;
      int unsigned      shift;
      int unsigned      scale;
      logic [7:0]       mask;
      logic [7:0]       value;
      pixel_result_type pixel;
      bpp = 1 << model_depth;
      per_byte = 8 / bpp;
      mask = 8'((1 << bpp) - 1);
      scale = 255 / mask;
      emitted = (count > per_byte) ? per_byte : count;
      for (int unsigned i = 0; i < emitted; i++) begin
         shift = bpp * (per_byte - 1 - i);
         value = (data >> shift) & mask;
         pixel.pixel_word = blend_pixel(8'(value * scale), back, fore);
         pixel.last_pixel = (i + 1 == emitted) ? glyph_end : 1'b0;
         expected_pixels.push_back(pixel);
      end
   endfunction

   // The previous request's valid is left high so back-to-back requests need no
   // second assignment in one time step; an idle gap lowers it.
   task automatic send_request(logic [7:0] data, logic [3:0] count, logic [15:0] back,
                               logic [15:0] fore, logic glyph_end);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_pixel_count <= count;
      req_back_color <= back;
      req_fore_color <= fore;
      req_glyph_end <= glyph_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixels(data, count, back, fore, glyph_end);
   endtask

   task automatic send_random_request(bit full_byte);
      logic [3:0]  count;
      logic [15:0] back;
      logic [15:0] fore;
      int          pick;
      pick = $urandom_range(0, 99);
      if (full_byte) begin
         count = 4'd8;
      end else if (pick < 6) begin
         count = 4'd0;
      end else if (pick < 14) begin
         count = 4'($urandom_range(9, 15));
      end else begin
         count = 4'($urandom_range(1, 8));
      end
      back = 16'($urandom);
      fore = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         back = 16'h0000;
         fore = 16'hffff;
      end else if (pick == 1) begin
         back = 16'hffff;
         fore = 16'h0000;
      end
      send_request(8'($urandom), count, back, fore, 1'($urandom));
   endtask

   // Zero-count requests leave nothing to wait for, so a settling wait follows.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_DEPTH) model_depth = value[1:0];
      @(posedge clock);
   endtask

   task automatic csr_check_depth();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_DEPTH;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[1:0] !== model_depth) begin
         note_mismatch("depth readback", {30'd0, model_depth}, prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_depth(logic [1:0] depth);
      wait_idle();
      csr_write(ADDR_DEPTH, {30'd0, depth});
      csr_check_depth();
   endtask

   // Reset leaves the block at eight bits per pixel.
   task automatic test_eight_bit();
      csr_check_depth();
      send_request(8'h00, 4'd1, 16'hffff, 16'h0000, 1'b1);
      send_request(8'hff, 4'd1, 16'h0000, 16'hffff, 1'b1);
      send_request(8'h80, 4'd15, 16'h1234, 16'hfedc, 1'b0);
      send_request(8'h7f, 4'd0, 16'hffff, 16'hffff, 1'b1);
      send_request(8'h55, 4'd8, 16'ha5a5, 16'h5a5a, 1'b1);
   endtask

   task automatic test_one_bit();
      set_depth(DEPTH_1BPP);
      send_request(8'ha5, 4'd8, 16'h0000, 16'hffff, 1'b1);
      send_request(8'h3c, 4'd3, 16'hf0f0, 16'h0f0f, 1'b1);
      send_request(8'hff, 4'd12, 16'hffff, 16'h0000, 1'b0);
      send_request(8'h01, 4'd0, 16'h1357, 16'h9bdf, 1'b1);
   endtask

   task automatic test_two_bit();
      set_depth(DEPTH_2BPP);
      send_request(8'h1b, 4'd4, 16'h0000, 16'hffff, 1'b1);
      send_request(8'he4, 4'd2, 16'h8421, 16'h7bde, 1'b0);
      send_request(8'hff, 4'd8, 16'hffff, 16'h0000, 1'b1);
   endtask

   task automatic test_four_bit();
      set_depth(DEPTH_4BPP);
      send_request(8'hf0, 4'd2, 16'h0000, 16'hffff, 1'b1);
      send_request(8'h0f, 4'd1, 16'hffff, 16'h0000, 1'b1);
      send_request(8'h8e, 4'd5, 16'hc3a9, 16'h365f, 1'b0);
   endtask

   // A write to an address with no register must leave the depth alone, and only
   // the low two data bits reach the depth register.
   task automatic test_register_decode();
      wait_idle();
      csr_write(ADDR_SPARE, 32'h0000_0000);
      csr_check_depth();
      send_request(8'h96, 4'd2, 16'h4c2e, 16'hb1d3, 1'b1);
      wait_idle();
      csr_write(ADDR_DEPTH, 32'hffff_fffc);
      csr_check_depth();
      send_request(8'h69, 4'd8, 16'h4c2e, 16'hb1d3, 1'b1);
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct);
      int start;
      wait_idle();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = $urandom_range(0, 3);
      for (int k = 0; k < 4; k++) begin
         set_depth(2'((start + k) % 4));
         repeat (ITEMS_PER_DEPTH) send_random_request(1'b0);
      end
   endtask

   // The receiver holds off while full bytes keep coming, so the queue fills up
   // and the request side has to stall.
   task automatic test_backpressure();
      set_depth(DEPTH_1BPP);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_pending++;
      repeat (16) send_random_request(1'b1);
   endtask

   task automatic test_sender_pause();
      set_depth(2'($urandom_range(0, 3)));
      send_idle_pct = 20;
      recv_idle_pct = 20;
      repeat (10) send_random_request(1'b0);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (10) send_random_request(1'b0);
   endtask

   always @(posedge clock) begin : receiver_stall
      if (hold_pending != hold_taken) begin
         hold_taken = hold_pending;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : pixel_checker
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            note_mismatch("unexpected pixel", 32'd0, rsp_pixel_word);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_word !== want.pixel_word) begin
               note_mismatch("pixel_word", want.pixel_word, rsp_pixel_word);
            end
            if (rsp_last_pixel !== want.last_pixel) begin
               note_mismatch("last_pixel", {31'd0, want.last_pixel}, {31'd0, rsp_last_pixel});
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_eight_bit();
      test_one_bit();
      test_two_bit();
      test_four_bit();
      test_register_decode();
      test_random_traffic(32, 53);
      test_random_traffic(53, 32);
      test_random_traffic(0, 0);
      test_backpressure();
      test_sender_pause();
      wait_idle();
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/gcub_pkg.sv
hw/rtl/gcub_front.sv
hw/rtl/gcub_queue.sv
hw/rtl/gcub_back.sv
hw/rtl/glyph_coverage_unpack_blend_core.sv
tb/sv/tb_top.sv
